// ===== sv/pcl_pkg.sv =====
// Shared constants, codes and types for the positional byte list.
`timescale 1ns / 1ps

package pcl_pkg;

  // Capacity of the list and derived widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int BYTE_W = 8;
  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;

  // Beat widths on the stream ports.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  // Commands broadcast to every cell of the chain.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;   // one of the CMD_* codes
    logic [CNT_W-1:0] pos;  // zero-based position of the insert or delete
    logic [CNT_W-1:0] len;  // current number of entries
  } cell_cmd_t;

endpackage

// ===== sv/pcl_cell.sv =====
// One storage cell of the list chain, updated from its neighbors by a shared command.
`timescale 1ns / 1ps

module pcl_cell (
  input  logic                              clk,
  input  logic [pcl_pkg::IDX_W-1:0]         idx,
  input  pcl_pkg::cell_cmd_t                cmd,
  input  logic [pcl_pkg::BYTE_W-1:0]        value_in,
  input  logic [pcl_pkg::BYTE_W-1:0]        left,
  input  logic [pcl_pkg::BYTE_W-1:0]        right,
  input  logic [pcl_pkg::BYTE_W-1:0]        head,
  output logic [pcl_pkg::BYTE_W-1:0]        data
);

  logic [pcl_pkg::BYTE_W-1:0] data_next;
  logic [pcl_pkg::CNT_W-1:0]  idx_ext;

  assign idx_ext = pcl_pkg::CNT_W'(idx);

  always_comb begin
    data_next = data;
    unique case (cmd.op)
      pcl_pkg::CMD_INS: begin
        // The new byte lands here; everything above moves up by one.
        if (idx_ext == cmd.pos) begin
          data_next = value_in;
        end else if (idx_ext > cmd.pos) begin
          data_next = left;
        end
      end
      pcl_pkg::CMD_DEL: begin
        if (idx_ext >= cmd.pos) begin
          data_next = right;
        end
      end
      pcl_pkg::CMD_ROT: begin
        // Rotate the occupied part down by one so the next entry reaches cell zero.
        if (idx_ext == cmd.len - pcl_pkg::CNT_W'(1)) begin
          data_next = head;
        end else begin
          data_next = right;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sv/positional_char_list.sv =====
// Top level of the positional byte list: control, length, result register and cell chain.
// Latency: a result beat appears in the cycle after its input beat is accepted.
// Insert, delete and unused actions yield one result beat.
// A dump of N entries yields one result beat per entry (one beat with no element
// when empty), as the rotation of the cell chain brings each entry to cell zero in turn.
// Reset (rst, synchronous, active high) empties the list and drops m_tvalid;
// cell contents are not cleared.
`timescale 1ns / 1ps

module positional_char_list (
  input  logic                               clk,
  input  logic                               rst,
  // Input beats.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pcl_pkg::IN_TDATA_W-1:0]     s_tdata,   // action[1:0], position[6:2],
                                                        // value[14:7], zero[15]
  // Result beats.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pcl_pkg::OUT_TDATA_W-1:0]    m_tdata,   // status[1:0], count[6:2],
                                                        // element[14:7], zero[15]
  output logic                               m_tuser,   // element_valid[0]
  output logic                               m_tlast    // last
);

  // Controller states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                         state;
  logic                         state_next;
  logic [pcl_pkg::CNT_W-1:0]    len;
  logic [pcl_pkg::CNT_W-1:0]    len_next;
  logic [pcl_pkg::CNT_W-1:0]    dump_cnt;
  logic [pcl_pkg::CNT_W-1:0]    dump_cnt_next;

  // Fields of the incoming beat.
  logic [pcl_pkg::ACT_W-1:0]    action;
  logic [pcl_pkg::CNT_W-1:0]    position;
  logic [pcl_pkg::BYTE_W-1:0]   value;

  assign action   = s_tdata[1:0];
  assign position = s_tdata[6:2];
  assign value    = s_tdata[14:7];

  // The result register is free when it is empty or being drained this cycle.
  logic out_free;
  logic accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // Position checks. Widened by one bit so that count+1 cannot wrap.
  logic ins_pos_ok;
  logic del_pos_ok;
  logic list_full;

  assign ins_pos_ok = (position != '0) &&
                      ({1'b0, position} <= ({1'b0, len} + (pcl_pkg::CNT_W + 1)'(1)));
  assign del_pos_ok = (position != '0) && (position <= len);
  assign list_full  = (len == pcl_pkg::CNT_W'(pcl_pkg::DEPTH));

  // The cell chain.
  pcl_pkg::cell_cmd_t           cmd;
  logic [pcl_pkg::BYTE_W-1:0]   cell_data [pcl_pkg::DEPTH];

  // Result of this cycle, loaded into the output register when emit is set.
  logic                         emit;
  logic [pcl_pkg::ST_W-1:0]     res_status;
  logic [pcl_pkg::BYTE_W-1:0]   res_element;
  logic                         res_valid;
  logic                         res_last;

  always_comb begin
    state_next    = state;
    len_next      = len;
    dump_cnt_next = dump_cnt;
    cmd.op        = pcl_pkg::CMD_NONE;
    cmd.pos       = position - pcl_pkg::CNT_W'(1);
    cmd.len       = len;
    emit          = 1'b0;
    res_status    = pcl_pkg::ST_OK;
    res_element   = '0;
    res_valid     = 1'b0;
    res_last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          case (action)
            pcl_pkg::ACT_INSERT: begin
              // The position check takes precedence over the full check.
              if (!ins_pos_ok) begin
                res_status = pcl_pkg::ST_INVALID;
              end else if (list_full) begin
                res_status = pcl_pkg::ST_FULL;
              end else begin
                cmd.op   = pcl_pkg::CMD_INS;
                len_next = len + pcl_pkg::CNT_W'(1);
              end
            end
            pcl_pkg::ACT_DELETE: begin
              // An empty list has no valid position, so this covers it too.
              if (!del_pos_ok) begin
                res_status = pcl_pkg::ST_INVALID;
              end else begin
                cmd.op   = pcl_pkg::CMD_DEL;
                len_next = len - pcl_pkg::CNT_W'(1);
              end
            end
            pcl_pkg::ACT_DUMP: begin
              // An empty dump gives a single beat with no element.
              if (len != '0) begin
                cmd.op      = pcl_pkg::CMD_ROT;
                res_element = cell_data[0];
                res_valid   = 1'b1;
                res_last    = (len == pcl_pkg::CNT_W'(1));
                if (len != pcl_pkg::CNT_W'(1)) begin
                  state_next    = S_DUMP;
                  dump_cnt_next = pcl_pkg::CNT_W'(1);
                end
              end
            end
            default: begin
              res_status = pcl_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_DUMP: begin
        // One entry per free output slot; the chain rotates as it is read.
        if (out_free) begin
          emit          = 1'b1;
          cmd.op        = pcl_pkg::CMD_ROT;
          res_element   = cell_data[0];
          res_valid     = 1'b1;
          res_last      = (dump_cnt == len - pcl_pkg::CNT_W'(1));
          dump_cnt_next = dump_cnt + pcl_pkg::CNT_W'(1);
          if (res_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < pcl_pkg::DEPTH; i++) begin : g_cell
    logic [pcl_pkg::BYTE_W-1:0] left_data;
    logic [pcl_pkg::BYTE_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_left
      assign left_data = cell_data[i-1];
    end

    if (i == pcl_pkg::DEPTH - 1) begin : g_final
      assign right_data = '0;
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
    end

    pcl_cell u_cell (
      .clk      (clk),
      .idx      (pcl_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .value_in (value),
      .left     (left_data),
      .right    (right_data),
      .head     (cell_data[0]),
      .data     (cell_data[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      dump_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      len      <= len_next;
      dump_cnt <= dump_cnt_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; the count reported is the length after the operation.
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0, res_element, len_next, res_status};
      m_tuser <= res_valid;
      m_tlast <= res_last;
    end
  end

endmodule

// ===== sv/pcl_checker.sv =====
// Port-level checks of the positional byte list, bound to the top level.
`timescale 1ns / 1ps

module pcl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pcl_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  // A beat carrying an element always reports success.
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[1:0] == pcl_pkg::ST_OK))
    else $error("element beat with non-ok status");

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:2] <= pcl_pkg::CNT_W'(pcl_pkg::DEPTH)))
    else $error("count above capacity");

  // Beats without an element carry a zero element byte.
  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[14:7] == '0))
    else $error("nonzero element on a beat without an element");

  // Only dump beats can be followed by more beats of the same input.
  a_nonlast_dump: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> m_tuser)
    else $error("non-final beat that is not a dump element");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("result beat changed while stalled");

endmodule

bind positional_char_list pcl_checker u_pcl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
